// ===== hdl/tsfe_pkg.sv =====
// Package for the time signal frame encoder: frame type, calendar constants
// and the small BCD and bit-placement helpers shared by the pipeline stages.
// No dependencies.
package tsfe_pkg;

    localparam int unsigned FRAME_W = 60;

    // JDN offset plus the truncated Julian day epoch, folded into one term.
    localparam logic [22:0] TJD_BASE = 23'd2472046;
    localparam logic [13:0] YEAR_SHIFT = 14'd4800;

    // Second positions of the least significant BCD bit of each field.
    localparam int unsigned TJD_TOP     = 33;
    localparam int unsigned YEAR_TOP    = 32;
    localparam int unsigned MONTH_TOP   = 37;
    localparam int unsigned WEEKDAY_TOP = 40;
    localparam int unsigned DAY_TOP     = 46;
    localparam int unsigned HOUR_TOP    = 52;
    localparam int unsigned MINUTE_TOP  = 59;

    typedef struct packed {
        logic [FRAME_W-1:0] first;
        logic [FRAME_W-1:0] second;
    } t_frame;

    // Low nibbles of floor(tjd / 10^k) for k = 0..4.
    typedef struct packed {
        logic [3:0] q0;
        logic [3:0] q1;
        logic [3:0] q2;
        logic [3:0] q3;
        logic [3:0] q4;
    } t_tjd_nibbles;

    // Two-digit BCD of a value below 100; tens found by reciprocal multiply.
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        prod     = 15'(v) * 15'(205);
        tens     = prod[14:11];
        tens_x10 = 7'(tens) * 7'(10);
        return {tens, 4'(v - tens_x10)};
    endfunction

    // Bit i of code goes to second (top - i), for i below n.
    function automatic logic [FRAME_W-1:0] place_bits(input logic [15:0] code,
                                                      input int unsigned top,
                                                      input int unsigned n);
        logic [FRAME_W-1:0] r;
        r = '0;
        for (int unsigned i = 0; i < 16; i++) begin
            if (i < n) begin
                r[6'(top - i)] = code[i];
            end
        end
        return r;
    endfunction

    // floor((153 * m + 2) / 5) for the March-based month index of each month.
    function automatic logic [8:0] month_offset(input logic [3:0] month);
        logic [8:0] r;
        case (month)
            4'd0:    r = 9'd275;
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            4'd13:   r = 9'd306;
            4'd14:   r = 9'd337;
            default: r = 9'd367;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/tsfe_dut1.sv =====
// DUT1 code decoder: turns the signed millisecond DUT1 value into the unary
// coarse and fine symbol bits of the frame. Depends on tsfe_pkg.
module tsfe_dut1 import tsfe_pkg::*; (
    input  logic signed [10:0] i_dut1_ms,
    output t_frame             o_code
);

    localparam logic [21:0] DIV100_MULT = 22'd2622;
    localparam logic [21:0] DIV20_MULT  = 22'd3277;

    logic        neg;
    logic [10:0] mag;
    logic [10:0] s100;
    logic [10:0] s20;
    logic [21:0] p100;
    logic [21:0] p20;
    logic [3:0]  q100;
    logic [5:0]  q20;
    logic [7:0]  fdiff;
    logic [7:0]  fabs;
    logic [3:0]  cmag;
    logic [2:0]  fmag;
    logic        c_neg;
    logic        f_neg;

    always_comb begin
        neg   = i_dut1_ms[10];
        mag   = neg ? 11'(~i_dut1_ms + 11'sd1) : 11'(i_dut1_ms);
        // Rounded magnitudes, half away from zero.
        s100  = mag + 11'd50;
        p100  = 22'(s100) * DIV100_MULT;
        q100  = p100[21:18];
        s20   = mag + 11'd10;
        p20   = 22'(s20) * DIV20_MULT;
        q20   = p20[21:16];
        fdiff = 8'(q20) - 8'(q100) * 8'(5);
        fabs  = fdiff[7] ? 8'(-fdiff) : fdiff;
        fmag  = (fabs > 8'd4) ? 3'd4 : fabs[2:0];
        cmag  = (q100 > 4'd8) ? 4'd8 : q100;
        c_neg = neg && (q100 != 4'd0);
        f_neg = (fdiff != 8'd0) && (neg ^ fdiff[7]);

        o_code = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < cmag) begin
                if (c_neg) begin
                    o_code.second[9 + i] = 1'b1;
                end else begin
                    o_code.second[1 + i] = 1'b1;
                end
            end
        end
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < fmag) begin
                if (c_neg) begin
                    o_code.first[3 + i] = 1'b1;
                end else begin
                    o_code.first[11 + i] = 1'b1;
                end
            end
        end
        if (f_neg) begin
            if (c_neg) begin
                o_code.first[7] = 1'b1;
            end else begin
                o_code.first[15] = 1'b1;
            end
        end
    end

endmodule

// ===== hdl/tsfe_calendar.sv =====
// Calendar stages: day number from year, month and day, clamped truncated
// Julian day, year modulo 100 and the BCD time fields. Depends on tsfe_pkg.
module tsfe_calendar import tsfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_adv,
    input  logic [11:0]        i_year,
    input  logic [3:0]         i_month,
    input  logic [4:0]         i_day,
    input  logic [2:0]         i_weekday,
    input  logic [4:0]         i_hour,
    input  logic [5:0]         i_minute,
    output logic [19:0]        o_tjd,
    output logic [6:0]         o_ymod,
    output logic [FRAME_W-1:0] o_first
);

    localparam logic [23:0] DIV25_MULT    = 24'd5243;
    localparam logic [24:0] YEAR_DIV_MULT = 25'd5243;

    // First stage: day number pieces.
    logic               am;
    logic [13:0]        y;
    logic [11:0]        q4;
    logic [23:0]        p25;
    logic [22:0]        y365;
    logic [24:0]        pyear;
    logic [22:0]        n_base;
    logic [6:0]         n_q100;
    logic [5:0]         n_yq;
    logic [FRAME_W-1:0] n_fields;
    logic [22:0]        r_base;
    logic [6:0]         r_q100;
    logic [5:0]         r_yq;
    logic [11:0]        r_year;
    logic [FRAME_W-1:0] r_fields;

    // Second stage: clamped day count and two-digit year.
    logic [22:0]        tjd_full;
    logic [11:0]        year_x100;
    logic [19:0]        n_tjd;
    logic [6:0]         n_ymod;
    logic [19:0]        r_tjd;
    logic [6:0]         r_ymod;
    logic [FRAME_W-1:0] r_first;

    always_comb begin
        am     = (i_month <= 4'd2);
        y      = YEAR_SHIFT + 14'(i_year) - 14'(am);
        q4     = y[13:2];
        p25    = 24'(q4) * DIV25_MULT;
        y365   = 23'(y) * 23'(365);
        n_base = 23'(i_day) + 23'(month_offset(i_month)) + y365 + 23'(q4) - TJD_BASE;
        n_q100 = p25[23:17];
        pyear  = 25'(i_year) * YEAR_DIV_MULT;
        n_yq   = pyear[24:19];
        n_fields = place_bits(16'(bcd2(7'(i_month))), MONTH_TOP, 5)
                 | place_bits(16'(i_weekday), WEEKDAY_TOP, 3)
                 | place_bits(16'(bcd2(7'(i_day))), DAY_TOP, 6)
                 | place_bits(16'(bcd2(7'(i_hour))), HOUR_TOP, 6)
                 | place_bits(16'(bcd2(7'(i_minute))), MINUTE_TOP, 7);
    end

    always_comb begin
        // Subtract floor(y/100), add floor(y/400).
        tjd_full  = r_base - 23'(r_q100) + 23'(r_q100[6:2]);
        n_tjd     = tjd_full[22] ? 20'd0 : tjd_full[19:0];
        year_x100 = 12'(r_yq) * 12'(100);
        n_ymod    = 7'(r_year - year_x100);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_base   <= n_base;
            r_q100   <= n_q100;
            r_yq     <= n_yq;
            r_year   <= i_year;
            r_fields <= n_fields;
            r_tjd    <= n_tjd;
            r_ymod   <= n_ymod;
            r_first  <= r_fields;
        end
    end

    assign o_tjd   = r_tjd;
    assign o_ymod  = r_ymod;
    assign o_first = r_first;

endmodule

// ===== hdl/tsfe_tjd_digits.sv =====
// Decimal split of the truncated Julian day by parallel reciprocal multiplies,
// and placement of the BCD year in the first symbols. Depends on tsfe_pkg.
module tsfe_tjd_digits import tsfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_adv,
    input  logic [19:0]        i_tjd,
    input  logic [6:0]         i_ymod,
    input  logic [FRAME_W-1:0] i_first,
    output t_tjd_nibbles       o_nibbles,
    output logic [FRAME_W-1:0] o_first
);

    localparam logic [40:0] DIV10_MULT    = 41'd1677722;
    localparam logic [40:0] DIV100_MULT   = 41'd1342178;
    localparam logic [40:0] DIV1000_MULT  = 41'd1073742;
    localparam logic [40:0] DIV10000_MULT = 41'd1717987;

    logic [40:0]        p10;
    logic [40:0]        p100;
    logic [40:0]        p1000;
    logic [40:0]        p10000;
    t_tjd_nibbles       n_nibbles;
    logic [FRAME_W-1:0] n_first;
    t_tjd_nibbles       r_nibbles;
    logic [FRAME_W-1:0] r_first;

    always_comb begin
        p10    = 41'(i_tjd) * DIV10_MULT;
        p100   = 41'(i_tjd) * DIV100_MULT;
        p1000  = 41'(i_tjd) * DIV1000_MULT;
        p10000 = 41'(i_tjd) * DIV10000_MULT;
        n_nibbles.q0 = i_tjd[3:0];
        n_nibbles.q1 = p10[27:24];
        n_nibbles.q2 = p100[30:27];
        n_nibbles.q3 = p1000[33:30];
        n_nibbles.q4 = p10000[37:34];
        n_first = i_first | place_bits(16'(bcd2(i_ymod)), YEAR_TOP, 8);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_nibbles <= n_nibbles;
            r_first   <= n_first;
        end
    end

    assign o_nibbles = r_nibbles;
    assign o_first   = r_first;

endmodule

// ===== hdl/time_signal_frame_encoder_core.sv =====
// Top level of the time signal minute frame encoder: input register, calendar
// and digit stages, frame assembly with parity, and the output register.
// Depends on tsfe_pkg, tsfe_dut1, tsfe_calendar and tsfe_tjd_digits.
//
// Usage: each input transaction carries one UTC timestamp (year, month, day,
// ISO weekday, hour, minute) and produces exactly one output transaction
// holding a 60-second frame as two 60-bit symbol words, bit s for second s.
// Both channels use valid/ready; a transaction completes on a rising edge
// where valid and ready are both high.
// The DUT1 value in milliseconds is written through i_cfg_wr_en and
// i_cfg_dut1_ms; it is decoded into its unary symbol bits right at the write,
// and every frame assembled after the write uses the new value.
// The pipeline has five register stages (input, day number, clamped day
// count, decimal digits, output) and takes one timestamp per cycle while
// the receiver does not stall.
// When the receiver stalls, the whole pipeline holds and o_in_ready falls
// only while a finished frame waits and the receiver keeps i_out_ready low.
// Synchronous active-low reset empties the pipeline and sets DUT1 to zero.
module time_signal_frame_encoder_core import tsfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port.
    input  logic               i_cfg_wr_en,
    input  logic signed [10:0] i_cfg_dut1_ms,
    // Timestamp input channel.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [11:0]        i_year,
    input  logic [3:0]         i_month,
    input  logic [4:0]         i_day,
    input  logic [2:0]         i_weekday,
    input  logic [4:0]         i_hour,
    input  logic [5:0]         i_minute,
    // Frame output channel.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [FRAME_W-1:0] o_first_symbol_bits,
    output logic [FRAME_W-1:0] o_second_symbol_bits
);

    // The pipeline moves as one unit whenever the output register is free or
    // its frame is being taken this cycle.
    logic               adv;

    // Valid flags of the input, day number, day count and digit stages.
    logic [3:0]         r_valid;
    logic               r_out_valid;

    // Decoded DUT1 symbol bits, held from the last configuration write.
    t_frame             dut1_code;
    t_frame             r_dut1;

    // Input register.
    logic [11:0]        r_year;
    logic [3:0]         r_month;
    logic [4:0]         r_day;
    logic [2:0]         r_weekday;
    logic [4:0]         r_hour;
    logic [5:0]         r_minute;

    logic [19:0]        cal_tjd;
    logic [6:0]         cal_ymod;
    logic [FRAME_W-1:0] cal_first;
    t_tjd_nibbles       dig_nibbles;
    logic [FRAME_W-1:0] dig_first;

    // Frame assembly.
    logic [15:0]        tjd_bcd;
    logic [FRAME_W-1:0] n_first;
    logic [FRAME_W-1:0] n_second;
    logic [FRAME_W-1:0] r_first;
    logic [FRAME_W-1:0] r_second;

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;

    tsfe_dut1 u_dut1 (
        .i_dut1_ms (i_cfg_dut1_ms),
        .o_code    (dut1_code)
    );

    tsfe_calendar u_calendar (
        .i_clk     (i_clk),
        .i_adv     (adv),
        .i_year    (r_year),
        .i_month   (r_month),
        .i_day     (r_day),
        .i_weekday (r_weekday),
        .i_hour    (r_hour),
        .i_minute  (r_minute),
        .o_tjd     (cal_tjd),
        .o_ymod    (cal_ymod),
        .o_first   (cal_first)
    );

    tsfe_tjd_digits u_tjd_digits (
        .i_clk     (i_clk),
        .i_adv     (adv),
        .i_tjd     (cal_tjd),
        .i_ymod    (cal_ymod),
        .i_first   (cal_first),
        .o_nibbles (dig_nibbles),
        .o_first   (dig_first)
    );

    always_comb begin
        // Each decimal digit is floor(t/10^k) - 10*floor(t/10^(k+1)); only the
        // low nibbles matter because the digit itself fits in four bits.
        tjd_bcd[3:0]   = dig_nibbles.q0 - 4'(dig_nibbles.q1 * 4'd10);
        tjd_bcd[7:4]   = dig_nibbles.q1 - 4'(dig_nibbles.q2 * 4'd10);
        tjd_bcd[11:8]  = dig_nibbles.q2 - 4'(dig_nibbles.q3 * 4'd10);
        tjd_bcd[15:12] = dig_nibbles.q3 - 4'(dig_nibbles.q4 * 4'd10);

        // The minute marker opens both symbol words.
        n_first  = dig_first | r_dut1.first | FRAME_W'(1);
        n_second = r_dut1.second | place_bits(tjd_bcd, TJD_TOP, 16) | FRAME_W'(1);

        // Even parity over the day count halves and the BCD field groups.
        n_second[49] = ^n_second[25:18];
        n_second[50] = ^n_second[33:26];
        n_second[53] = ^n_first[24:19];
        n_second[54] = ^n_first[32:25];
        n_second[55] = ^n_first[40:33];
        n_second[56] = ^n_first[46:41];
        n_second[57] = ^n_first[52:47];
        n_second[58] = ^n_first[59:53];
    end

    // Control state: stage valid flags and the DUT1 code register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_dut1      <= '0;
        end else begin
            if (adv) begin
                r_valid     <= {r_valid[2:0], i_in_valid};
                r_out_valid <= r_valid[3];
            end
            if (i_cfg_wr_en) begin
                r_dut1 <= dut1_code;
            end
        end
    end

    // Payload registers follow the pipeline advance and need no reset.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_year    <= i_year;
            r_month   <= i_month;
            r_day     <= i_day;
            r_weekday <= i_weekday;
            r_hour    <= i_hour;
            r_minute  <= i_minute;
            r_first   <= n_first;
            r_second  <= n_second;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_first_symbol_bits  = r_first;
    assign o_second_symbol_bits = r_second;

endmodule
